// ===== rtl/esed_pkg.sv =====
// ----------------------------------------------------------------------------
// esed_pkg: shared types and constants of the encoder switch event decoder
// Event codes, register indexes, reset values, the quadrature step table
// and the event bundle that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package esed_pkg;

  localparam int PIN_W        = 6;
  localparam int PINS_PER_ENC = 3;
  localparam int NUM_ENC      = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DEBOUNCE_W = 16;
  localparam int DETENT_W   = 5;
  localparam int LONG_W     = 16;
  localparam int STEP_W     = 6;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DETENT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd2;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET   = 16'd20;
  localparam logic [DETENT_W-1:0]   DETENT_RESET     = 5'd4;
  localparam logic [LONG_W-1:0]     LONG_PRESS_RESET = 16'd800;

  localparam logic [2:0] EV_LEFT_ROTATE  = 3'd0;
  localparam logic [2:0] EV_RIGHT_ROTATE = 3'd1;
  localparam logic [2:0] EV_LEFT_CLICK   = 3'd2;
  localparam logic [2:0] EV_RIGHT_CLICK  = 3'd3;
  localparam logic [2:0] EV_RIGHT_LONG   = 3'd4;

  localparam logic signed [1:0] DIR_NONE = 2'sd0;
  localparam logic signed [1:0] DIR_CW   = 2'sd1;
  localparam logic signed [1:0] DIR_CCW  = -2'sd1;

  localparam logic [1:0] PHASE_IDLE = 2'b11;

  localparam int MAX_EVENTS  = 4;
  localparam int EV_IDX_W    = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0]        kind;
    logic signed [1:0] dir;
  } event_t;

  typedef struct packed {
    event_t [MAX_EVENTS-1:0] ev;
    logic [EV_IDX_W-1:0]     last_pos;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Index is {previous phase, new phase}, each phase being {B, A}.
  function automatic logic signed [1:0] phase_step(input logic [3:0] idx);
    logic signed [1:0] step;
    unique case (idx)
      4'b0001, 4'b0111, 4'b1110, 4'b1000: step = DIR_CW;
      4'b0010, 4'b1011, 4'b1101, 4'b0100: step = DIR_CCW;
      default:                            step = DIR_NONE;
    endcase
    return step;
  endfunction

endpackage

// ===== rtl/esed_front.sv =====
// ----------------------------------------------------------------------------
// esed_front: sample decoder
// Holds the configuration registers and the per-encoder state, decodes one
// pin sample per accepted cycle and packs the events it causes into one bundle.
// ----------------------------------------------------------------------------
module esed_front #(
  parameter int TIMER_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [esed_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [esed_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_accept,
  input  logic [esed_pkg::PIN_W-1:0]     pin_sample,
  output logic                           push,
  output esed_pkg::bundle_t              bundle
);
  import esed_pkg::*;

  localparam int CMP_W = (TIMER_BITS > DEBOUNCE_W) ? TIMER_BITS : DEBOUNCE_W;

  logic [DEBOUNCE_W-1:0] debounce_ticks;
  logic [DETENT_W-1:0]   detent_ticks;
  logic [LONG_W-1:0]     long_press_ticks;

  logic [1:0]               prev_phase [NUM_ENC];
  logic signed [STEP_W-1:0] step_count [NUM_ENC];
  logic [NUM_ENC-1:0]       raw_level;
  logic [NUM_ENC-1:0]       stable_level;
  logic [TIMER_BITS-1:0]    since_change [NUM_ENC];
  logic [TIMER_BITS-1:0]    held_time;
  logic [NUM_ENC-1:0]       long_fired;

  logic [1:0]               prev_phase_next [NUM_ENC];
  logic signed [STEP_W-1:0] step_count_next [NUM_ENC];
  logic [NUM_ENC-1:0]       raw_level_next;
  logic [NUM_ENC-1:0]       stable_level_next;
  logic [TIMER_BITS-1:0]    since_change_next [NUM_ENC];
  logic [TIMER_BITS-1:0]    held_time_next;
  logic [NUM_ENC-1:0]       long_fired_next;

  logic [NUM_ENC-1:0]       rot_fire;
  logic signed [1:0]        rot_dir [NUM_ENC];
  logic [NUM_ENC-1:0]       click_fire;
  logic                     long_fire;

  always_comb begin
    logic [1:0]               phase;
    logic                     sw;
    logic signed [1:0]        step;
    logic signed [STEP_W:0]   sum;
    logic signed [STEP_W:0]   det;
    phase = '0;
    sw    = 1'b0;
    step  = DIR_NONE;
    sum   = '0;
    det   = {2'b00, detent_ticks};
    prev_phase_next   = prev_phase;
    step_count_next   = step_count;
    raw_level_next    = raw_level;
    stable_level_next = stable_level;
    since_change_next = since_change;
    long_fired_next   = long_fired;
    rot_fire          = '0;
    click_fire        = '0;
    long_fire         = 1'b0;
    for (int i = 0; i < NUM_ENC; i++) begin
      rot_dir[i] = DIR_NONE;
    end
    held_time_next = (&held_time) ? held_time : held_time + 1'b1;

    for (int i = 0; i < NUM_ENC; i++) begin
      phase = pin_sample[PINS_PER_ENC*i +: 2];
      sw    = pin_sample[PINS_PER_ENC*i + 2];
      step  = phase_step({prev_phase[i], phase});
      sum   = {step_count[i][STEP_W-1], step_count[i]} + {{(STEP_W-1){step[1]}}, step};

      // A rotate event fires as soon as the count reaches a detent either way.
      if (step != DIR_NONE) begin
        if (sum >= det) begin
          step_count_next[i] = '0;
          rot_fire[i]        = 1'b1;
          rot_dir[i]         = DIR_CW;
        end else if (sum <= -det) begin
          step_count_next[i] = '0;
          rot_fire[i]        = 1'b1;
          rot_dir[i]         = DIR_CCW;
        end else begin
          step_count_next[i] = sum[STEP_W-1:0];
        end
      end
      prev_phase_next[i] = phase;

      if (sw != raw_level[i]) begin
        raw_level_next[i]    = sw;
        since_change_next[i] = '0;
      end else begin
        since_change_next[i] = (&since_change[i]) ? since_change[i]
                                                  : since_change[i] + 1'b1;
      end

      if ((CMP_W'(since_change_next[i]) >= CMP_W'(debounce_ticks)) &&
          (sw != stable_level[i])) begin
        stable_level_next[i] = sw;
        if (!sw) begin
          if (i == 1) begin
            held_time_next = '0;
          end
          long_fired_next[i] = 1'b0;
        end else if (!long_fired[i]) begin
          click_fire[i] = 1'b1;
        end
      end
    end

    // Only the second switch has a long press.
    if (!stable_level_next[1] && !long_fired_next[1] &&
        (CMP_W'(held_time_next) >= CMP_W'(long_press_ticks))) begin
      long_fired_next[1] = 1'b1;
      long_fire          = 1'b1;
    end
  end

  // Pack the events in encoder order into the lowest bundle slots.
  always_comb begin
    event_t                cand [5];
    logic [4:0]            cand_v;
    logic [EV_IDX_W:0]     n;
    cand[0] = '{kind: EV_LEFT_ROTATE,  dir: rot_dir[0]};
    cand[1] = '{kind: EV_LEFT_CLICK,   dir: DIR_NONE};
    cand[2] = '{kind: EV_RIGHT_ROTATE, dir: rot_dir[1]};
    cand[3] = '{kind: EV_RIGHT_CLICK,  dir: DIR_NONE};
    cand[4] = '{kind: EV_RIGHT_LONG,   dir: DIR_NONE};
    cand_v  = {long_fire, click_fire[1], rot_fire[1], click_fire[0], rot_fire[0]};
    n       = '0;
    bundle  = '0;
    for (int k = 0; k < 5; k++) begin
      if (cand_v[k]) begin
        bundle.ev[n[EV_IDX_W-1:0]] = cand[k];
        n = n + 1'b1;
      end
    end
    bundle.last_pos = n[EV_IDX_W-1:0] - 1'b1;
    push            = in_accept && (n != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_RESET;
      detent_ticks     <= DETENT_RESET;
      long_press_ticks <= LONG_PRESS_RESET;
      for (int i = 0; i < NUM_ENC; i++) begin
        prev_phase[i]   <= PHASE_IDLE;
        step_count[i]   <= '0;
        since_change[i] <= '0;
      end
      raw_level    <= '1;
      stable_level <= '1;
      held_time    <= '0;
      long_fired   <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_DEBOUNCE:   debounce_ticks   <= cfg_data[DEBOUNCE_W-1:0];
          REG_DETENT:     detent_ticks     <= cfg_data[DETENT_W-1:0];
          REG_LONG_PRESS: long_press_ticks <= cfg_data[LONG_W-1:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        prev_phase   <= prev_phase_next;
        step_count   <= step_count_next;
        raw_level    <= raw_level_next;
        stable_level <= stable_level_next;
        since_change <= since_change_next;
        held_time    <= held_time_next;
        long_fired   <= long_fired_next;
      end
    end
  end

endmodule

// ===== rtl/esed_queue.sv =====
// ----------------------------------------------------------------------------
// esed_queue: bundle queue
// A short first-in first-out queue of event bundles between the decoder and
// the event sequencer.
// ----------------------------------------------------------------------------
module esed_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  esed_pkg::bundle_t     wr_data,
  input  logic                  pop,
  output esed_pkg::bundle_t     rd_data,
  output esed_pkg::q_status_t   stat
);
  import esed_pkg::*;

  bundle_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign rd_data    = mem[rd_ptr];
  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/esed_back.sv =====
// ----------------------------------------------------------------------------
// esed_back: event sequencer
// Takes one bundle at a time from the queue and hands its events out one
// per cycle while out_stall is low, marking the final event of each sample.
// ----------------------------------------------------------------------------
module esed_back (
  input  logic                  clk,
  input  logic                  rst,
  input  esed_pkg::bundle_t     head,
  input  esed_pkg::q_status_t   q_stat,
  output logic                  pop,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [2:0]            event_kind,
  output logic signed [1:0]     direction,
  output logic                  last_event
);
  import esed_pkg::*;

  bundle_t              cur;
  logic                 cur_valid;
  logic [EV_IDX_W-1:0]  pos;
  logic                 take;
  logic                 at_last;
  logic                 finish;

  assign at_last = (pos == cur.last_pos);
  assign take    = cur_valid && !out_stall;
  assign finish  = take && at_last;
  assign pop     = (!cur_valid || finish) && !q_stat.empty;

  assign out_valid  = cur_valid;
  assign event_kind = cur.ev[pos].kind;
  assign direction  = cur.ev[pos].dir;
  assign last_event = at_last;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        pos       <= '0;
      end else if (finish) begin
        cur_valid <= 1'b0;
      end else if (take) begin
        pos <= pos + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/encoder_switch_event_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// encoder_switch_event_decoder_unit: two rotary encoders with push switches
// Decodes 1 ms pin polls into rotate, click and long-press events.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+--------------------------------
//  input    | in        | in_valid / in_stall | pin_sample[5:0]
//  output   | out       | out_valid/out_stall | event_kind, direction, last_event
//  config   | in        | cfg_valid/cfg_ready | cfg_index[1:0], cfg_data[15:0]
//
// The decoder takes one pin sample per cycle while in_stall is low and turns
// it into a bundle of zero to four events in that same cycle; a two-entry
// bundle queue follows. The sequencer puts out one event per cycle while
// out_stall is low, so the events of one sample leave one after another.
// in_stall rises only while the bundle queue is full; a sample that causes
// no event never enters the queue. Configuration writes are registered and
// cfg_ready is always high. Synchronous reset sets the state registers to
// the idle-high line state and documented defaults, not the bundle data.
// ----------------------------------------------------------------------------
module encoder_switch_event_decoder_unit #(
  parameter int TIMER_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [esed_pkg::PIN_W-1:0]      pin_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      event_kind,
  output logic signed [1:0]               direction,
  output logic                            last_event,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [esed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [esed_pkg::CFG_DATA_W-1:0] cfg_data
);
  import esed_pkg::*;

  logic      in_accept;
  logic      front_push;
  bundle_t   front_bundle;
  bundle_t   q_head;
  q_status_t q_stat;
  logic      back_pop;

  // A request is accepted whenever the queue can take its bundle.
  assign in_stall  = q_stat.full;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  esed_front #(
    .TIMER_BITS(TIMER_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_accept  (in_accept),
    .pin_sample (pin_sample),
    .push       (front_push),
    .bundle     (front_bundle)
  );

  esed_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (front_push),
    .wr_data (front_bundle),
    .pop     (back_pop),
    .rd_data (q_head),
    .stat    (q_stat)
  );

  esed_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_stat     (q_stat),
    .pop        (back_pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .event_kind (event_kind),
    .direction  (direction),
    .last_event (last_event)
  );

  // The decoder never writes a bundle into a full queue.
  assert property (@(posedge clk) disable iff (rst) !(front_push && q_stat.full))
    else $error("bundle pushed into a full queue");

  // Bundles enter the queue only for accepted samples.
  assert property (@(posedge clk) disable iff (rst) front_push |-> in_accept)
    else $error("bundle pushed without an accepted sample");

  // Rotate events carry a direction and all other events carry none.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (((event_kind == EV_LEFT_ROTATE) || (event_kind == EV_RIGHT_ROTATE))
                   == (direction != DIR_NONE)))
    else $error("direction does not match event kind");

endmodule
